// ===== rtl/dtb_pkg.sv =====
package dtb_pkg;

  localparam int ModeW   = 3;
  localparam int AmountW = 15;
  localparam int CellW   = 8;
  localparam int StatusW = 2;

  localparam logic [ModeW-1:0] MODE_SET   = 3'd0;
  localparam logic [ModeW-1:0] MODE_ADD   = 3'd1;
  localparam logic [ModeW-1:0] MODE_SUB   = 3'd2;
  localparam logic [ModeW-1:0] MODE_LEFT  = 3'd3;
  localparam logic [ModeW-1:0] MODE_RIGHT = 3'd4;
  localparam logic [ModeW-1:0] MODE_PUSH  = 3'd5;
  localparam logic [ModeW-1:0] MODE_POP   = 3'd6;
  localparam logic [ModeW-1:0] MODE_READ  = 3'd7;

  localparam logic [StatusW-1:0] ST_OK        = 2'd0;
  localparam logic [StatusW-1:0] ST_POP_EMPTY = 2'd1;
  localparam logic [StatusW-1:0] ST_PUSH_FULL = 2'd2;
  localparam logic [StatusW-1:0] ST_RANGE     = 2'd3;

  typedef struct packed {
    logic               rd_en;
    logic               commit;
    logic [ModeW-1:0]   mode;
    logic [CellW-1:0]   operand;
  } tape_ctl_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } stk_sts_t;

endpackage

// ===== rtl/data_tape_with_bookmarks_core.sv =====
// Byte-cell data tape with a bookmark stack.
// Input channel: mode_i/amount_i with in_valid_i, stalled by in_stall_o.
// Output channel: current_value_o, at_beginning_o, at_end_o, status_o with
// out_valid_o, stalled by out_stall_i. One result word per command word.
// The cells sit in a single-port synchronous RAM: each command reads the
// cell under the new head and, for set/add/sub, writes the modified cell back
// before the next command is taken, so no two accesses overlap.
// The result is registered from the read stage into the output register; a
// pop first reads the bookmark RAM to find the head.
// A new command is taken only after the last one has left the read stage;
// the cell RAM read/write-back sets this.
// Reset: head, visited limits and bookmark count clear at once; then the
// cell RAM is swept to zero, one cell per cycle over all TAPE_DEPTH cells, while
// in_stall_o is held high.
// A stalled result stays on the output register; the next command is still
// taken and waits in the read stage until the output register frees.
module data_tape_with_bookmarks_core import dtb_pkg::*; #(
  parameter int TAPE_DEPTH     = 32768,
  parameter int BOOKMARK_DEPTH = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [ModeW-1:0]          mode_i,
  input  logic [AmountW-1:0]        amount_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [CellW-1:0]   current_value_o,
  output logic                      at_beginning_o,
  output logic                      at_end_o,
  output logic [StatusW-1:0]        status_o
);

  localparam int AddrW = $clog2(TAPE_DEPTH);
  localparam int SumW  = ((AddrW > AmountW) ? AddrW : AmountW) + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [AddrW-1:0]   head_q, head_d;
  logic [AddrW-1:0]   low_q, low_d;
  logic [AddrW-1:0]   high_q, high_d;
  logic [ModeW-1:0]   mode_q;
  logic [CellW-1:0]   operand_q;
  logic [StatusW-1:0] status_q, status_d;
  logic               out_valid_q, out_valid_d;
  logic [CellW-1:0]   value_q;
  logic               beg_q, end_q;
  logic [StatusW-1:0] out_status_q;

  logic               accept;
  logic               out_load;
  logic               tape_busy;
  logic [CellW-1:0]   cell_new;
  logic [AddrW-1:0]   tape_addr;
  logic [AddrW-1:0]   pop_head;
  logic [SumW-1:0]    head_ext, amt_ext, right_sum;
  tape_ctl_t          tape_ctl;
  stk_ctl_t           stk_ctl;
  stk_sts_t           stk_sts;

  assign in_stall_o = (state_q != S_IDLE) || tape_busy;
  assign accept     = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == S_READ) && (!out_valid_q || !out_stall_i);

  assign head_ext  = SumW'(head_q);
  assign amt_ext   = SumW'(amount_i);
  assign right_sum = head_ext + amt_ext;

  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    low_d    = low_q;
    high_d   = high_q;
    status_d = status_q;
    stk_ctl  = '0;
    tape_addr = head_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          status_d = ST_OK;
          state_d  = S_READ;
          unique case (mode_i)
            MODE_LEFT: begin
              if (amt_ext > head_ext) begin
                status_d = ST_RANGE;
              end else begin
                head_d = head_q - AddrW'(amount_i);
                if (head_d < low_q) begin
                  low_d = head_d;
                end
              end
            end
            MODE_RIGHT: begin
              if (right_sum >= SumW'(TAPE_DEPTH)) begin
                status_d = ST_RANGE;
              end else begin
                head_d = right_sum[AddrW-1:0];
                if (head_d > high_q) begin
                  high_d = head_d;
                end
              end
            end
            MODE_PUSH: begin
              if (stk_sts.full) begin
                status_d = ST_PUSH_FULL;
              end else begin
                stk_ctl.push = 1'b1;
              end
            end
            MODE_POP: begin
              if (stk_sts.empty) begin
                status_d = ST_POP_EMPTY;
              end else begin
                stk_ctl.pop = 1'b1;
                state_d     = S_POP;
              end
            end
            default: ;
          endcase
          tape_addr = head_d;
        end
      end
      S_POP: begin
        head_d    = pop_head;
        tape_addr = pop_head;
        state_d   = S_READ;
      end
      S_READ: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    tape_ctl.rd_en   = (accept && !stk_ctl.pop) || (state_q == S_POP);
    tape_ctl.commit  = out_load;
    tape_ctl.mode    = mode_q;
    tape_ctl.operand = operand_q;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      low_q       <= '0;
      high_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      low_q       <= low_d;
      high_q      <= high_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    if (accept) begin
      mode_q    <= mode_i;
      operand_q <= amount_i[CellW-1:0];
    end
    if (out_load) begin
      value_q      <= cell_new;
      beg_q        <= (head_q == low_q);
      end_q        <= (head_q == high_q);
      out_status_q <= status_q;
    end
  end

  dtb_tape #(
    .TAPE_DEPTH (TAPE_DEPTH),
    .AddrW      (AddrW)
  ) u_tape (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (tape_ctl),
    .addr_i (tape_addr),
    .busy_o (tape_busy),
    .cell_o (cell_new)
  );

  dtb_bookmarks #(
    .BOOKMARK_DEPTH (BOOKMARK_DEPTH),
    .DataW          (AddrW)
  ) u_bookmarks (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (stk_ctl),
    .push_data_i (head_q),
    .sts_o       (stk_sts),
    .pop_data_o  (pop_head)
  );

  assign out_valid_o     = out_valid_q;
  assign current_value_o = $signed(value_q);
  assign at_beginning_o  = beg_q;
  assign at_end_o        = end_q;
  assign status_o        = out_status_q;

endmodule

// ===== rtl/dtb_tape.sv =====
module dtb_tape import dtb_pkg::*; #(
  parameter int TAPE_DEPTH = 32768,
  parameter int AddrW      = $clog2(TAPE_DEPTH)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tape_ctl_t        ctl_i,
  input  logic [AddrW-1:0] addr_i,
  output logic             busy_o,
  output logic [CellW-1:0] cell_o
);

  logic [CellW-1:0] mem [TAPE_DEPTH];
  logic [CellW-1:0] rdata_q;
  logic [AddrW-1:0] addr_q;
  logic [AddrW-1:0] clr_idx_q, clr_idx_d;
  logic             busy_q, busy_d;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [CellW-1:0] wr_data;
  logic             is_arith;

  // sweep zeros through the store after reset
  always_comb begin
    clr_idx_d = clr_idx_q;
    busy_d    = busy_q;
    if (busy_q) begin
      clr_idx_d = clr_idx_q + AddrW'(1);
      if (clr_idx_q == AddrW'(TAPE_DEPTH - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q <= '0;
      busy_q    <= 1'b1;
    end else begin
      clr_idx_q <= clr_idx_d;
      busy_q    <= busy_d;
    end
  end

  always_comb begin
    unique case (ctl_i.mode)
      MODE_SET: cell_o = ctl_i.operand;
      MODE_ADD: cell_o = rdata_q + ctl_i.operand;
      MODE_SUB: cell_o = rdata_q - ctl_i.operand;
      default:  cell_o = rdata_q;
    endcase
  end

  assign is_arith = (ctl_i.mode == MODE_SET) || (ctl_i.mode == MODE_ADD) ||
                    (ctl_i.mode == MODE_SUB);
  assign wr_en    = busy_q || (ctl_i.commit && is_arith);
  assign wr_addr  = busy_q ? clr_idx_q : addr_q;
  assign wr_data  = busy_q ? '0 : cell_o;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl_i.rd_en) begin
      rdata_q <= mem[addr_i];
      addr_q  <= addr_i;
    end
  end

  assign busy_o = busy_q;

endmodule

// ===== rtl/dtb_bookmarks.sv =====
module dtb_bookmarks import dtb_pkg::*; #(
  parameter int BOOKMARK_DEPTH = 16,
  parameter int DataW          = 15,
  parameter int IdxW           = (BOOKMARK_DEPTH > 1) ? $clog2(BOOKMARK_DEPTH) : 1,
  parameter int CntW           = $clog2(BOOKMARK_DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  stk_ctl_t         ctl_i,
  input  logic [DataW-1:0] push_data_i,
  output stk_sts_t         sts_o,
  output logic [DataW-1:0] pop_data_o
);

  logic [DataW-1:0] mem [BOOKMARK_DEPTH];
  logic [DataW-1:0] rdata_q;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CntW-1:0]  cnt_dec;

  assign cnt_dec = cnt_q - CntW'(1);

  always_comb begin
    cnt_d = cnt_q;
    if (ctl_i.push) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (ctl_i.pop) begin
      cnt_d = cnt_dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      mem[cnt_q[IdxW-1:0]] <= push_data_i;
    end
    if (ctl_i.pop) begin
      rdata_q <= mem[cnt_dec[IdxW-1:0]];
    end
  end

  assign sts_o.full  = (cnt_q == CntW'(BOOKMARK_DEPTH));
  assign sts_o.empty = (cnt_q == '0);
  assign pop_data_o  = rdata_q;

endmodule

// ===== tb/data_tape_check.sv =====
`timescale 1ns / 100ps

module data_tape_check import dtb_pkg::*; #(
  parameter int TAPE_DEPTH     = 32768,
  parameter int BOOKMARK_DEPTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic [ModeW-1:0]        mode_i,
  input  logic [AmountW-1:0]      amount_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic signed [CellW-1:0] current_value_i,
  input  logic                    at_beginning_i,
  input  logic                    at_end_i,
  input  logic [StatusW-1:0]      status_i,
  output int                      errors_o,
  output int                      pending_o
);

  typedef struct packed {
    logic [CellW-1:0]   value;
    logic               at_begin;
    logic               at_end;
    logic [StatusW-1:0] status;
  } head_view_t;

  logic [CellW-1:0] cells [TAPE_DEPTH];
  int unsigned      head_pos;
  int unsigned      low_mark;
  int unsigned      high_mark;
  int unsigned      marks [BOOKMARK_DEPTH];
  int unsigned      mark_count;
  head_view_t       view_q [$];

  initial begin
    for (int i = 0; i < TAPE_DEPTH; i++) cells[i] = '0;
    head_pos   = 0;
    low_mark   = 0;
    high_mark  = 0;
    mark_count = 0;
    errors_o   = 0;
    pending_o  = 0;
  end

  function automatic head_view_t apply_command(input logic [ModeW-1:0] mode,
                                               input logic [AmountW-1:0] amount);
    head_view_t  v;
    int unsigned amt;
    amt      = amount;
    v.status = ST_OK;
    case (mode)
      MODE_SET: cells[head_pos] = amount[CellW-1:0];
      MODE_ADD: cells[head_pos] = cells[head_pos] + amount[CellW-1:0];
      MODE_SUB: cells[head_pos] = cells[head_pos] - amount[CellW-1:0];
      MODE_LEFT: begin
        if (amt > head_pos) begin
          v.status = ST_RANGE;
        end else begin
          head_pos = head_pos - amt;
          if (head_pos < low_mark) low_mark = head_pos;
        end
      end
      MODE_RIGHT: begin
        if (head_pos + amt >= TAPE_DEPTH) begin
          v.status = ST_RANGE;
        end else begin
          head_pos = head_pos + amt;
          if (head_pos > high_mark) high_mark = head_pos;
        end
      end
      MODE_PUSH: begin
        if (mark_count >= BOOKMARK_DEPTH) begin
          v.status = ST_PUSH_FULL;
        end else begin
          marks[mark_count] = head_pos;
          mark_count++;
        end
      end
      MODE_POP: begin
        if (mark_count == 0) begin
          v.status = ST_POP_EMPTY;
        end else begin
          mark_count--;
          head_pos = marks[mark_count];
        end
      end
      default: ;
    endcase
    v.value    = cells[head_pos];
    v.at_begin = (head_pos == low_mark);
    v.at_end   = (head_pos == high_mark);
    return v;
  endfunction

  always @(posedge clk_i) begin
    head_view_t want;
    if (rst_ni && out_valid_i && !out_stall_i) begin
      if (view_q.size() == 0) begin
        errors_o++;
        $display("%0t: unexpected result word value %h status %0d", $time,
                 current_value_i, status_i);
      end else begin
        want = view_q.pop_front();
        if (current_value_i !== want.value) begin
          errors_o++;
          $display("%0t: current_value exp %h got %h", $time, want.value,
                   current_value_i);
        end
        if (at_beginning_i !== want.at_begin) begin
          errors_o++;
          $display("%0t: at_beginning exp %b got %b", $time, want.at_begin,
                   at_beginning_i);
        end
        if (at_end_i !== want.at_end) begin
          errors_o++;
          $display("%0t: at_end exp %b got %b", $time, want.at_end, at_end_i);
        end
        if (status_i !== want.status) begin
          errors_o++;
          $display("%0t: status exp %0d got %0d", $time, want.status, status_i);
        end
      end
    end
    if (rst_ni && in_valid_i && !in_stall_i) view_q.push_back(apply_command(mode_i, amount_i));
    pending_o = view_q.size();
  end

endmodule

// ===== tb/tb_data_tape_with_bookmarks_core.sv =====
`timescale 1ns / 100ps

module tb_data_tape_with_bookmarks_core;
  import dtb_pkg::*;

  localparam int TapeDepth     = 32768;
  localparam int BookmarkDepth = 16;
  localparam int NumWords      = 1300;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [ModeW-1:0]        mode_i;
  logic [AmountW-1:0]      amount_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic signed [CellW-1:0] current_value_o;
  logic                    at_beginning_o;
  logic                    at_end_o;
  logic [StatusW-1:0]      status_o;

  int errors;
  int pending;
  int sent;
  bit calm;

  data_tape_with_bookmarks_core #(
    .TAPE_DEPTH    (TapeDepth),
    .BOOKMARK_DEPTH(BookmarkDepth)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .amount_i       (amount_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .current_value_o(current_value_o),
    .at_beginning_o (at_beginning_o),
    .at_end_o       (at_end_o),
    .status_o       (status_o)
  );

  data_tape_check #(
    .TAPE_DEPTH    (TapeDepth),
    .BOOKMARK_DEPTH(BookmarkDepth)
  ) u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .mode_i         (mode_i),
    .amount_i       (amount_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .current_value_i(current_value_o),
    .at_beginning_i (at_beginning_o),
    .at_end_i       (at_end_o),
    .status_i       (status_o),
    .errors_o       (errors),
    .pending_o      (pending)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 14);
  end

  task automatic send_word(input logic [ModeW-1:0] m, input logic [AmountW-1:0] a);
    while (!calm && $urandom_range(99) < 14) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= m;
    amount_i   <= a;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent++;
  endtask

  // short hop, cell edit or read, keeps the head near its visited range
  task automatic send_nearby();
    int unsigned pick;
    pick = $urandom_range(5);
    case (pick)
      0: send_word(MODE_SET, AmountW'($urandom()));
      1: send_word(MODE_ADD, AmountW'($urandom()));
      2: send_word(MODE_SUB, AmountW'($urandom()));
      3: send_word(MODE_LEFT, AmountW'($urandom_range(7)));
      4: send_word(MODE_RIGHT, AmountW'($urandom_range(7)));
      default: send_word(MODE_READ, AmountW'($urandom()));
    endcase
  endtask

  initial begin
    int unsigned pick;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    mode_i      <= MODE_READ;
    amount_i    <= '0;
    out_stall_i <= 1'b0;
    sent = 0;
    calm = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_word(MODE_READ, '0);
    send_word(MODE_SET, 15'h007F);
    send_word(MODE_ADD, 15'h0001);
    send_word(MODE_SUB, 15'h7F01);
    send_word(MODE_ADD, 15'h0000);
    send_word(MODE_SUB, 15'h7F00);
    send_word(MODE_SET, 15'h7FFF);
    send_word(MODE_LEFT, 15'd1);
    send_word(MODE_RIGHT, 15'd0);
    send_word(MODE_POP, 15'h5555);
    send_word(MODE_PUSH, 15'h2AAA);
    send_word(MODE_RIGHT, AmountW'(TapeDepth - 1));
    send_word(MODE_SET, 15'h0080);
    send_word(MODE_RIGHT, 15'd1);
    send_word(MODE_LEFT, 15'd0);
    send_word(MODE_POP, '0);
    send_word(MODE_RIGHT, AmountW'(TapeDepth - 1));
    send_word(MODE_LEFT, AmountW'(TapeDepth - 1));
    send_word(MODE_RIGHT, 15'd3);
    send_word(MODE_LEFT, 15'd4);
    send_word(MODE_LEFT, 15'd3);

    while (sent < NumWords) begin
      calm = (sent >= 500 && sent < 800);
      pick = $urandom_range(99);
      if (pick < 40) begin
        send_nearby();
      end else if (pick < 48) begin
        send_word($urandom_range(1) ? MODE_LEFT : MODE_RIGHT, AmountW'($urandom()));
      end else if (pick < 54) begin
        send_word(MODE_PUSH, AmountW'($urandom()));
      end else if (pick < 60) begin
        send_word(MODE_POP, AmountW'($urandom()));
      end else if (pick < 97) begin
        send_word(MODE_PUSH, AmountW'($urandom()));
        repeat ($urandom_range(1, 6)) send_nearby();
        if ($urandom_range(3) == 0)
          send_word($urandom_range(1) ? MODE_LEFT : MODE_RIGHT, AmountW'($urandom()));
        send_word(MODE_POP, AmountW'($urandom()));
      end else begin
        repeat (BookmarkDepth + $urandom_range(1, 3)) begin
          send_word(MODE_PUSH, AmountW'($urandom()));
          if ($urandom_range(1)) send_word(MODE_RIGHT, AmountW'($urandom_range(3)));
        end
        repeat (BookmarkDepth + $urandom_range(1, 3)) send_word(MODE_POP, AmountW'($urandom()));
      end
    end
    in_valid_i <= 1'b0;
    calm = 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("tb: failure");
    $finish;
  end

endmodule
